// ----- design/cst_pkg.sv -----
// Shared types and constants for the CSV stream tokenizer.
// No dependencies; imported by every module of the block.
package cst_pkg;

    typedef enum logic [1:0] {
        KIND_FIELD_BYTE   = 2'd0,
        KIND_FIELD_END    = 2'd1,
        KIND_ROW_END      = 2'd2,
        KIND_END_OF_INPUT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_UNTERM_QUOTE    = 3'd1,
        ST_WIDTH_MISMATCH  = 3'd2,
        ST_MISSING_HEADER  = 3'd3,
        ST_COLUMN_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  field_byte;
        logic [6:0]  column_index;
        logic        is_header_row;
        status_t     status;
        logic        last;
    } result_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] DELIMITER_RESET  = 8'd44;
    localparam logic       HAS_HEADER_RESET = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_DELIMITER  = 1'b0;
    localparam logic REG_HAS_HEADER = 1'b1;

endpackage

// ----- design/cst_parse_core.sv -----
// Tokenizer state and per-byte decode: turns one registered input item into
// up to two results. Depends on cst_pkg.
module cst_parse_core #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic              item_eoi,
    input  logic              advance,
    input  logic [7:0]        delimiter,
    input  logic              has_header,
    output cst_pkg::result_t  res0,
    output cst_pkg::result_t  res1,
    output logic [1:0]        res_count
);
    import cst_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLUMNS);

    logic          in_quotes_reg, in_quotes_next;
    logic          quote_pending_reg, quote_pending_next;
    logic          row_started_reg, row_started_next;
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [CW-1:0] reference_width_reg, reference_width_next;
    logic          first_row_done_reg, first_row_done_next;

    logic            hdr_now;
    logic            over;
    status_t         fstat;
    logic [CW+6:0]   col_wide;
    logic [6:0]      col7;
    logic [CW-1:0]   row_width;
    status_t         row_stat;
    result_t         byte_res;
    result_t         row_res;
    result_t         eoi_res;
    logic            unquoted;

    always_comb begin
        hdr_now   = has_header && !first_row_done_reg;
        over      = (column_count_reg >= MAX_CNT);
        fstat     = over ? ST_COLUMN_OVERFLOW : ST_OK;
        col_wide  = {7'd0, column_count_reg};
        col7      = col_wide[6:0];
        row_width = over ? MAX_CNT : column_count_reg + CW'(1);

        if (!first_row_done_reg || over) begin
            row_stat = fstat;
        end else if (row_width != reference_width_reg) begin
            row_stat = ST_WIDTH_MISMATCH;
        end else begin
            row_stat = ST_OK;
        end

        byte_res = '{kind: KIND_FIELD_BYTE, field_byte: item_byte, column_index: col7,
                     is_header_row: hdr_now, status: fstat, last: 1'b1};
        row_res  = '{kind: KIND_ROW_END, field_byte: 8'd0, column_index: col7,
                     is_header_row: hdr_now, status: row_stat, last: 1'b1};
        eoi_res  = '{kind: KIND_END_OF_INPUT, field_byte: 8'd0, column_index: 7'd0,
                     is_header_row: hdr_now, status: ST_OK, last: 1'b1};
    end

    always_comb begin
        in_quotes_next       = in_quotes_reg;
        quote_pending_next   = quote_pending_reg;
        row_started_next     = row_started_reg;
        column_count_next    = column_count_reg;
        reference_width_next = reference_width_reg;
        first_row_done_next  = first_row_done_reg;
        res0      = byte_res;
        res1      = eoi_res;
        res_count = 2'd0;
        unquoted  = 1'b1;

        if (item_eoi) begin
            if (in_quotes_reg && !quote_pending_reg) begin
                res0        = eoi_res;
                res0.status = ST_UNTERM_QUOTE;
                res_count   = 2'd1;
            end else if (row_started_reg) begin
                // row end closes the partial row; the header phase is over after it
                res0      = row_res;
                res0.last = 1'b0;
                res1.is_header_row = 1'b0;
                res_count = 2'd2;
            end else begin
                res0        = eoi_res;
                res0.status = hdr_now ? ST_MISSING_HEADER : ST_OK;
                res_count   = 2'd1;
            end
            in_quotes_next       = 1'b0;
            quote_pending_next   = 1'b0;
            row_started_next     = 1'b0;
            column_count_next    = '0;
            reference_width_next = '0;
            first_row_done_next  = 1'b0;
        end else begin
            row_started_next = 1'b1;
            if (quote_pending_reg) begin
                quote_pending_next = 1'b0;
                if (item_byte == CH_QUOTE) begin
                    res_count = 2'd1;
                    unquoted  = 1'b0;
                end else begin
                    in_quotes_next = 1'b0;
                end
            end else if (in_quotes_reg) begin
                if (item_byte == CH_QUOTE) begin
                    quote_pending_next = 1'b1;
                end else begin
                    res_count = 2'd1;
                end
                unquoted = 1'b0;
            end

            if (unquoted) begin
                if (item_byte == CH_QUOTE) begin
                    in_quotes_next = 1'b1;
                end else if (item_byte == CH_CR) begin
                    res_count = 2'd0;
                end else if (item_byte == CH_LF) begin
                    res0      = row_res;
                    res_count = 2'd1;
                    if (!first_row_done_reg) begin
                        reference_width_next = row_width;
                        first_row_done_next  = 1'b1;
                    end
                    column_count_next  = '0;
                    row_started_next   = 1'b0;
                    in_quotes_next     = 1'b0;
                    quote_pending_next = 1'b0;
                end else if (item_byte == delimiter) begin
                    res0.kind       = KIND_FIELD_END;
                    res0.field_byte = 8'd0;
                    res_count       = 2'd1;
                    if (!over) begin
                        column_count_next = column_count_reg + CW'(1);
                    end
                end else begin
                    res_count = 2'd1;
                end
            end
        end

        if (!item_valid) begin
            res_count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg       <= 1'b0;
            quote_pending_reg   <= 1'b0;
            row_started_reg     <= 1'b0;
            column_count_reg    <= '0;
            reference_width_reg <= '0;
            first_row_done_reg  <= 1'b0;
        end else if (advance) begin
            in_quotes_reg       <= in_quotes_next;
            quote_pending_reg   <= quote_pending_next;
            row_started_reg     <= row_started_next;
            column_count_reg    <= column_count_next;
            reference_width_reg <= reference_width_next;
            first_row_done_reg  <= first_row_done_next;
        end
    end

endmodule

// ----- design/cst_result_fifo.sv -----
// Two-entry result queue: takes up to two results per cycle, hands out one.
// Depends on cst_pkg.
module cst_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  cst_pkg::result_t  push0,
    input  cst_pkg::result_t  push1,
    input  logic              pop_ready,
    output logic [1:0]        free_slots,
    output logic              head_valid,
    output cst_pkg::result_t  head
);
    import cst_pkg::*;

    result_t    entry_reg [2];
    result_t    entry_next [2];
    logic [1:0] count_reg, count_next;
    logic [1:0] count_left;
    logic       pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[0];
    assign pop        = head_valid && pop_ready;
    assign free_slots = 2'd2 - count_reg + {1'b0, pop};

    always_comb begin
        entry_next = entry_reg;
        count_left = count_reg;
        if (pop) begin
            entry_next[0] = entry_reg[1];
            count_left    = count_reg - 2'd1;
        end
        // caller only pushes what fits, so count_left is 0 or 1 here
        if (push_count != 2'd0) begin
            entry_next[count_left[0]] = push0;
        end
        if (push_count == 2'd2) begin
            entry_next[1] = push1;
        end
        count_next = count_left + push_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/csv_stream_tokenizer.sv -----
// CSV stream tokenizer top level: APB register file, input register, parse core
// and result queue. Depends on cst_pkg, cst_parse_core and cst_result_fifo.
//
// One item enters per cycle while the input register can move on. An item passes
// the input register and the decode logic and its results sit in a two-entry
// result queue, so a result is held in the input register and then in the queue
// before it shows on m_*. Byte items give at most one result and stream at one per
// cycle while m_ready stays high; an end-of-input item closing a partial row gives
// two results and needs both queue entries, so it waits in the input register
// until the queue is empty after that cycle's pop. Registers: delimiter at
// 0x0 (reset 44), has_header at 0x4 (reset 1); write them only while no
// transaction is in flight.
module csv_stream_tokenizer #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_field_byte,
    output logic [6:0]  m_column_index,
    output logic        m_is_header_row,
    output logic [2:0]  m_status,
    output logic        m_last
);
    import cst_pkg::*;

    logic [7:0] delimiter_reg;
    logic       has_header_reg;
    logic       cfg_write;

    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_eoi_reg;

    result_t    res0, res1, head;
    logic [1:0] res_count, push_count, free_slots;
    logic       advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg  <= DELIMITER_RESET;
            has_header_reg <= HAS_HEADER_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_DELIMITER) begin
                delimiter_reg <= pwdata[7:0];
            end else begin
                has_header_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HAS_HEADER) begin
            prdata = {31'd0, has_header_reg};
        end else begin
            prdata = {24'd0, delimiter_reg};
        end
    end

    // input stage moves on once its results fit in the queue
    assign advance    = item_valid_reg && (res_count <= free_slots);
    assign push_count = advance ? res_count : 2'd0;
    assign s_ready    = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_byte_reg <= s_data_byte;
            item_eoi_reg  <= s_end_of_input;
        end
    end

    cst_parse_core #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid_reg),
        .item_byte  (item_byte_reg),
        .item_eoi   (item_eoi_reg),
        .advance    (advance),
        .delimiter  (delimiter_reg),
        .has_header (has_header_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    cst_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop_ready  (m_ready),
        .free_slots (free_slots),
        .head_valid (m_valid),
        .head       (head)
    );

    assign m_kind          = head.kind;
    assign m_field_byte    = head.field_byte;
    assign m_column_index  = head.column_index;
    assign m_is_header_row = head.is_header_row;
    assign m_status        = head.status;
    assign m_last          = head.last;

endmodule

// ----- design/cst_checker.sv -----
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on cst_pkg and csv_stream_tokenizer.
module cst_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_field_byte,
    input logic [6:0] m_column_index,
    input logic [2:0] m_status,
    input logic       m_last
);
    import cst_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_field_byte)
            && $stable(m_column_index) && $stable(m_status) && $stable(m_last))
        else $error("stalled result changed");

    a_eoi_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END_OF_INPUT |-> m_last)
        else $error("end-of-input result not marked last");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_kind == KIND_END_OF_INPUT)
        else $error("non-last result not followed by end of input");

    a_unterm_eoi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNTERM_QUOTE |-> m_kind == KIND_END_OF_INPUT)
        else $error("unterminated quote status on a non end-of-input result");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_field_byte   (m_field_byte),
    .m_column_index (m_column_index),
    .m_status       (m_status),
    .m_last         (m_last)
);
